[rtl/core/ufl_pkg.sv]
// ----------------------------------------------------------------------------
// ufl_pkg
// Shared constants and types for the user id free list allocator.
// ----------------------------------------------------------------------------
package ufl_pkg;

   localparam int MAX_IDS = 64;
   localparam int DEPTH   = MAX_IDS + 1;
   localparam int ID_W    = $clog2(DEPTH);

   typedef enum logic {
      CMD_ATTACH = 1'b0,
      CMD_DETACH = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_REFUSED = 2'd1,
      ST_BUSY    = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   // one word of the link store: allocated flag plus next free id
   typedef struct packed {
      logic            alloc;
      logic [ID_W-1:0] link;
   } link_entry_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] addr;
      link_entry_type  data;
   } link_wr_type;

endpackage

[rtl/core/ufl_link_store.sv]
// ----------------------------------------------------------------------------
// ufl_link_store
// Link and allocated-flag memory, one read and one write port, registered
// read data. Entries never written read back as their reset value.
// ----------------------------------------------------------------------------
module ufl_link_store
   import ufl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            rd_en,
   input  logic [ID_W-1:0] rd_addr,
   input  link_wr_type     wr,
   output link_entry_type  rd_entry
);

   link_entry_type  mem [DEPTH];
   link_entry_type  rd_data_ff;
   logic [ID_W-1:0] rd_addr_ff;
   logic [DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   // untouched entry: free, chained to the id below it
   always_comb begin
      if (valid_ff[rd_addr_ff]) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry.alloc = 1'b0;
         rd_entry.link  = (rd_addr_ff == '0) ? '0 : rd_addr_ff - ID_W'(1);
      end
   end

endmodule

[rtl/core/user_id_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// user_id_free_list_allocator
// Hands out user ids 1..MAX_IDS from a LIFO free list and takes them back.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An item first reads
// the link store at the free-list head (attach) or at the named id (detach);
// then busy is high while the entry is updated and written back together
// with the head and the user count. The result appears on the rsp_ ports,
// marked by rsp_valid, for exactly one cycle in the cycle after that; no new
// item is taken while busy is high. The receiver cannot stall; each item
// gives exactly one result. The service_running register must be written
// through csr_wr_en only while no item is in flight; the block itself does
// not enforce this. After reset the block takes items at once.
// ----------------------------------------------------------------------------
module user_id_free_list_allocator
   import ufl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic            req_cmd,
   input  logic            req_has_callback,
   input  logic [ID_W-1:0] req_user_id,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [ID_W-1:0] rsp_granted_id,
   output logic            rsp_notify,
   output logic [ID_W-1:0] rsp_active_users,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type       state_ff, state_in;
   logic            cmd_ff, cb_ff, uid_ok_ff;
   logic [ID_W-1:0] uid_ff;
   logic [ID_W-1:0] head_ff, head_in;
   logic [ID_W-1:0] count_ff, count_in;
   logic            running_ff;
   logic            rsp_valid_ff;
   status_type      status_ff, status_in;
   logic [ID_W-1:0] granted_ff, granted_in;
   logic            notify_ff, notify_in;

   logic            accept;
   logic            uid_ok;
   logic [ID_W-1:0] rd_addr;
   link_entry_type  entry;
   link_wr_type     wr;

   assign busy   = (state_ff == S_EXEC);
   assign accept = start & ~busy;
   assign uid_ok = (req_user_id != '0) && (req_user_id <= ID_W'(MAX_IDS));
   assign rd_addr = (req_cmd == CMD_DETACH) ? (uid_ok ? req_user_id : '0) : head_ff;

   ufl_link_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .wr       (wr),
      .rd_entry (entry)
   );

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      status_in  = ST_OK;
      granted_in = '0;
      notify_in  = 1'b0;
      wr.en      = 1'b0;
      wr.addr    = head_ff;
      wr.data    = '{alloc: 1'b1, link: '0};
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            if (cmd_ff == CMD_ATTACH) begin
               if (!running_ff && !cb_ff) begin
                  status_in = ST_REFUSED;
               end else if (head_ff == '0) begin
                  status_in = ST_BUSY;
               end else begin
                  // pop the head
                  wr.en      = 1'b1;
                  head_in    = entry.link;
                  granted_in = head_ff;
                  notify_in  = cb_ff & running_ff;
                  if (count_ff != ID_W'(MAX_IDS)) begin
                     count_in = count_ff + ID_W'(1);
                  end
               end
            end else begin
               if (!uid_ok_ff || !entry.alloc) begin
                  status_in = ST_IGNORED;
               end else begin
                  // push the released id onto the head
                  wr.en   = 1'b1;
                  wr.addr = uid_ff;
                  wr.data = '{alloc: 1'b0, link: head_ff};
                  head_in = uid_ff;
                  if (count_ff != '0) begin
                     count_in = count_ff - ID_W'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= ID_W'(MAX_IDS);
         count_ff     <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
         granted_ff   <= '0;
         notify_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= busy;
         if (busy) begin
            status_ff  <= status_in;
            granted_ff <= granted_in;
            notify_ff  <= notify_in;
         end
         if (csr_wr_en) begin
            running_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         cb_ff     <= req_has_callback;
         uid_ff    <= req_user_id;
         uid_ok_ff <= uid_ok;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_id   = granted_ff;
   assign rsp_notify       = notify_ff;
   assign rsp_active_users = count_ff;

endmodule
